// ===== src/mncs_pkg.sv =====
//------------------------------------------------------------------------------
// mncs_pkg
// Shared constants for the 3D mask neighbour-count scrub block.
//------------------------------------------------------------------------------
package mncs_pkg;
    localparam int DEF_MAX_X = 64;
    localparam int DEF_MAX_Y = 64;
    localparam int DEF_MAX_Z = 64;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 18;
    localparam int COORD_W   = 6;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ADJUST    = 3'd5;

    localparam logic [7:0] FILL_VALUE = 8'd255;
endpackage

// ===== src/mncs_voxel_ram.sv =====
//------------------------------------------------------------------------------
// mncs_voxel_ram
// Single-port byte memory, registered read.
//------------------------------------------------------------------------------
module mncs_voxel_ram #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== src/mask_neighbour_count_scrub_3d.sv =====
//------------------------------------------------------------------------------
// mask_neighbour_count_scrub_3d
// 3D byte mask with label volume; load, read and in-place 6-neighbour scrub.
//------------------------------------------------------------------------------
// A write word gives its result on done the cycle after it is accepted, and busy
// stays low. A read word raises busy for 1 cycle and gives its result on done
// after the registered memory read in ST_READ. A run word reads each interior
// voxel and, if it matches the mode, its six neighbours, one per cycle through
// the single mask port (ST_CENTER, ST_NBR), and writes back a changed voxel, and
// its label in ST_LABEL and ST_LWRITE if labels are adjusted, before ST_NEXT.
// The run result comes the cycle after the last voxel's ST_NEXT, or the cycle
// after acceptance when there is no interior. Each word gives one result on
// done, which the receiver must take in that cycle; it cannot stall the block.
module mask_neighbour_count_scrub_3d
    import mncs_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  logic [1:0]           kind,
    input  logic [COORD_W-1:0]   coord_x,
    input  logic [COORD_W-1:0]   coord_y,
    input  logic [COORD_W-1:0]   coord_z,
    input  logic [7:0]           mask_in,
    input  logic [7:0]           label_in,
    output logic [7:0]           mask_out,
    output logic [7:0]           label_out,
    output logic [CNT_W-1:0]     changed_count,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int XW    = $clog2(MAX_X);
    localparam int YW    = $clog2(MAX_Y);
    localparam int ZW    = $clog2(MAX_Z);
    localparam int AW    = XW + YW + ZW;
    localparam int DEPTH = 1 << AW;
    localparam int EW    = $clog2(MAX_X + 1) > 7 ? $clog2(MAX_X + 1) : 7;
    localparam int EYW   = $clog2(MAX_Y + 1) > 7 ? $clog2(MAX_Y + 1) : 7;
    localparam int EZW   = $clog2(MAX_Z + 1) > 7 ? $clog2(MAX_Z + 1) : 7;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_CENTER, ST_NBR, ST_LABEL, ST_LWRITE, ST_NEXT
    } state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    size_x_reg, size_y_reg, size_z_reg;
    logic [2:0]          thr_reg;
    logic                mode_reg, adj_reg;
    logic [XW-1:0]       x_reg;
    logic [YW-1:0]       y_reg;
    logic [ZW-1:0]       z_reg;
    logic [2:0]          nbr_reg;
    logic [2:0]          cnt_reg;
    logic [CNT_W-1:0]    chg_reg;
    logic                done_reg;
    logic                rd_ok_reg;
    logic [7:0]          mask_o_reg, label_o_reg;
    logic [CNT_W-1:0]    count_o_reg;

    logic [EW-1:0]  ex;
    logic [EYW-1:0] ey;
    logic [EZW-1:0] ez;
    assign ex = (EW'(size_x_reg) > EW'(MAX_X)) ? EW'(MAX_X) : EW'(size_x_reg);
    assign ey = (EYW'(size_y_reg) > EYW'(MAX_Y)) ? EYW'(MAX_Y) : EYW'(size_y_reg);
    assign ez = (EZW'(size_z_reg) > EZW'(MAX_Z)) ? EZW'(MAX_Z) : EZW'(size_z_reg);

    logic coord_ok;
    assign coord_ok = (EW'(coord_x) < ex) && (EYW'(coord_y) < ey) && (EZW'(coord_z) < ez);

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // mask and label memory ports
    logic          m_we, l_we;
    logic [AW-1:0] m_addr, l_addr;
    logic [7:0]    m_wdata, l_wdata, m_rdata, l_rdata;

    logic [AW-1:0] in_addr, cur_addr;
    assign in_addr  = {ZW'(coord_z), YW'(coord_y), XW'(coord_x)};
    assign cur_addr = {z_reg, y_reg, x_reg};

    // neighbour fetched next; data for neighbour nbr_reg is on m_rdata
    logic [AW-1:0] nbr_addr;
    always_comb
    begin
        case (nbr_reg)
            3'd0:    nbr_addr = {z_reg, y_reg, x_reg - XW'(1)};
            3'd1:    nbr_addr = {z_reg, y_reg + YW'(1), x_reg};
            3'd2:    nbr_addr = {z_reg, y_reg - YW'(1), x_reg};
            3'd3:    nbr_addr = {z_reg + ZW'(1), y_reg, x_reg};
            3'd4:    nbr_addr = {z_reg - ZW'(1), y_reg, x_reg};
            default: nbr_addr = cur_addr;
        endcase
    end

    logic match;
    assign match = mode_reg ? (m_rdata == 8'd0) : (m_rdata != 8'd0);

    logic [2:0] cnt_fin;
    assign cnt_fin = cnt_reg + 3'(match);

    logic last_x, last_y, last_z;
    assign last_x = (EW'(x_reg) + EW'(2) >= ex);
    assign last_y = (EYW'(y_reg) + EYW'(2) >= ey);
    assign last_z = (EZW'(z_reg) + EZW'(2) >= ez);

    logic [AW-1:0] next_addr;
    always_comb
    begin
        next_addr = {z_reg, y_reg, x_reg + XW'(1)};
        if (last_x)
        begin
            next_addr = {z_reg, y_reg + YW'(1), XW'(1)};
            if (last_y)
            begin
                next_addr = {z_reg + ZW'(1), YW'(1), XW'(1)};
            end
        end
    end

    logic change;
    assign change = (nbr_reg == 3'd5) && (cnt_fin < thr_reg);

    always_comb
    begin
        m_we    = 1'b0;
        l_we    = 1'b0;
        m_wdata = mask_in;
        l_wdata = label_in;
        m_addr  = cur_addr;
        l_addr  = cur_addr;
        case (state_reg)
            ST_IDLE:
            begin
                m_addr = in_addr;
                l_addr = in_addr;
                if (accept && kind == KIND_WRITE && coord_ok)
                begin
                    m_we = 1'b1;
                    l_we = 1'b1;
                end
                if (accept && kind == KIND_RUN)
                begin
                    m_addr = {ZW'(1), YW'(1), XW'(1)};
                end
            end
            ST_CENTER:
            begin
                m_addr = {z_reg, y_reg, x_reg + XW'(1)};
            end
            ST_NBR:
            begin
                m_addr = nbr_addr;
                if (change)
                begin
                    m_addr  = cur_addr;
                    m_we    = 1'b1;
                    m_wdata = mode_reg ? FILL_VALUE : 8'd0;
                end
            end
            ST_LWRITE:
            begin
                l_we    = 1'b1;
                l_wdata = mode_reg ? l_rdata + 8'd1 : l_rdata - 8'd1;
            end
            ST_NEXT:
            begin
                m_addr = next_addr;
            end
            default:
            begin
                m_addr = cur_addr;
            end
        endcase
    end

    mncs_voxel_ram #(.DEPTH(DEPTH), .AW(AW)) u_mask (
        .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
    mncs_voxel_ram #(.DEPTH(DEPTH), .AW(AW)) u_label (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            size_x_reg <= 7'd64;
            size_y_reg <= 7'd64;
            size_z_reg <= 7'd64;
            thr_reg    <= 3'd3;
            mode_reg   <= 1'b0;
            adj_reg    <= 1'b0;
            done_reg   <= 1'b0;
            rd_ok_reg  <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            z_reg      <= '0;
            nbr_reg    <= '0;
            cnt_reg    <= '0;
            chg_reg    <= '0;
            mask_o_reg <= '0;
            label_o_reg <= '0;
            count_o_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SIZE_X:    size_x_reg <= cfg_data;
                    REG_SIZE_Y:    size_y_reg <= cfg_data;
                    REG_SIZE_Z:    size_z_reg <= cfg_data;
                    REG_THRESHOLD: thr_reg    <= cfg_data[2:0];
                    REG_MODE:      mode_reg   <= cfg_data[0];
                    REG_ADJUST:    adj_reg    <= cfg_data[0];
                    default:       ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        mask_o_reg  <= '0;
                        label_o_reg <= '0;
                        count_o_reg <= '0;
                        rd_ok_reg   <= coord_ok;
                        x_reg       <= XW'(1);
                        y_reg       <= YW'(1);
                        z_reg       <= ZW'(1);
                        chg_reg     <= '0;
                        if (kind == KIND_READ)
                        begin
                            state_reg <= ST_READ;
                        end
                        else if (kind == KIND_RUN)
                        begin
                            if (ex < EW'(3) || ey < EYW'(3) || ez < EZW'(3))
                            begin
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= ST_CENTER;
                            end
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                ST_READ:
                begin
                    if (rd_ok_reg)
                    begin
                        mask_o_reg  <= m_rdata;
                        label_o_reg <= l_rdata;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_CENTER:
                begin
                    nbr_reg <= 3'd0;
                    cnt_reg <= 3'd0;
                    state_reg <= match ? ST_NBR : ST_NEXT;
                end
                ST_NBR:
                begin
                    cnt_reg <= cnt_fin;
                    nbr_reg <= nbr_reg + 3'd1;
                    if (nbr_reg == 3'd5)
                    begin
                        if (change)
                        begin
                            chg_reg   <= chg_reg + CNT_W'(1);
                            state_reg <= adj_reg ? ST_LABEL : ST_NEXT;
                        end
                        else
                        begin
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_LABEL:
                begin
                    state_reg <= ST_LWRITE;
                end
                ST_LWRITE:
                begin
                    state_reg <= ST_NEXT;
                end
                default:
                begin
                    if (last_x)
                    begin
                        x_reg <= XW'(1);
                        if (last_y)
                        begin
                            y_reg <= YW'(1);
                            if (last_z)
                            begin
                                count_o_reg <= chg_reg;
                                done_reg    <= 1'b1;
                                state_reg   <= ST_IDLE;
                            end
                            else
                            begin
                                z_reg     <= z_reg + ZW'(1);
                                state_reg <= ST_CENTER;
                            end
                        end
                        else
                        begin
                            y_reg     <= y_reg + YW'(1);
                            state_reg <= ST_CENTER;
                        end
                    end
                    else
                    begin
                        x_reg     <= x_reg + XW'(1);
                        state_reg <= ST_CENTER;
                    end
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign mask_out      = mask_o_reg;
    assign label_out     = label_o_reg;
    assign changed_count = count_o_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done || $past(accept))
        else $error("done held");
    a_nbr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NBR) |-> (nbr_reg <= 3'd5))
        else $error("neighbour index out of range");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(busy)) |-> !busy)
        else $error("busy after run done");
endmodule
